>>> design/yfr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// yfr_pkg: shared types and constants for the YMODEM frame receiver
// Item structs, command and response codes, and the CRC-16 byte update.
// ============================================================================
package yfr_pkg;

    localparam logic [15:0] CrcPoly   = 16'h1021;
    localparam logic [10:0] ShortLen  = 11'd128;
    localparam logic [10:0] LongLen   = 11'd1024;
    localparam logic [7:0]  ByteSoh   = 8'h01;
    localparam logic [7:0]  ByteStx   = 8'h02;
    localparam logic [7:0]  ByteEot   = 8'h04;
    localparam logic [7:0]  ByteSpace = 8'h20;
    localparam logic [7:0]  ByteZero  = 8'h30;
    localparam int          QueueDepth = 2;

    localparam logic [1:0] CfgLongBlocks = 2'd0;
    localparam logic [1:0] CfgNakInterval = 2'd1;
    localparam logic [1:0] CfgTimeout = 2'd2;

    localparam logic [1:0] CmdByte  = 2'd0;
    localparam logic [1:0] CmdTick  = 2'd1;
    localparam logic [1:0] CmdStart = 2'd2;

    localparam logic [2:0] RespNone = 3'd0;
    localparam logic [2:0] RespAck  = 3'd1;
    localparam logic [2:0] RespNak  = 3'd2;
    localparam logic [2:0] RespC    = 3'd3;
    localparam logic [2:0] RespCan  = 3'd4;

    localparam logic [1:0] StatRun     = 2'd0;
    localparam logic [1:0] StatDone    = 2'd1;
    localparam logic [1:0] StatTimeout = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_BLOCK = 2'd2,
        PH_EOT   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,
        K_TICK  = 2'd1,
        K_START = 2'd2,
        K_NOP   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  response;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_index;
        logic [10:0] commit_length;
        logic        open_file;
        logic [31:0] file_size;
        logic        close_file;
        logic [1:0]  session_status;
    } out_item_t;

    // classified item as it travels from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       is_soh;
        logic       is_stx;
        logic       is_eot;
        logic       is_nul;
        logic       is_space;
    } cls_item_t;

    typedef struct packed {
        logic       long_blocks;
        logic [7:0] nak_interval;
        logic [7:0] timeout;
    } cfg_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CrcPoly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> design/ymodem_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// ymodem_frame_receiver_unit: YMODEM receive engine with CRC-16
// Frames SOH/STX blocks, checks block number and CRC, parses block 0.
// ============================================================================
// Usage:
//   in_valid/in_ready/in_item carry one item each: a received byte, a
//   millisecond tick or a start command. out_valid/out_ready/out_item return
//   exactly one result item per input item: the reply to send, the payload
//   byte with its index, the commit length of a passed block, file open and
//   close events and the session status.
//   A result item passes through the queue entry and then the engine with
//   its result register. Throughput is one item per cycle while out_ready
//   is high and no remainder recompute runs; the engine updates CRC,
//   counters and size parse as each byte is popped.
//   A stalled out_ready holds the result register; the two-entry queue
//   absorbs items until it fills, then in_ready drops.
//   Writing nak_interval starts a recompute of the tick remainder;
//   in_ready is low while it runs.
//   Reset (rst_n low, asynchronous) leaves the session idle with the
//   register defaults: long blocks on, NAK interval 25, timeout 200.
// ============================================================================
module ymodem_frame_receiver_unit
    import yfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t      cfg_reg, cfg_next;
    logic      interval_written;
    logic      q_push, q_pop, q_full, q_not_empty, back_busy;
    cls_item_t push_item, q_head;

    // hold the config registers; user must write only while idle, unchecked
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CfgLongBlocks:  cfg_next.long_blocks  = cfg_data[0];
                CfgNakInterval: cfg_next.nak_interval = cfg_data;
                CfgTimeout:     cfg_next.timeout      = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign interval_written = cfg_we && (cfg_index == CfgNakInterval);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_blocks  <= 1'b1;
            cfg_reg.nak_interval <= 8'd25;
            cfg_reg.timeout      <= 8'd200;
        end
        else
            cfg_reg <= cfg_next;
    end

    // classify and accept
    yfr_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .q_full    (q_full),
        .back_busy (back_busy),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // decouple front from the engine
    yfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (q_head)
    );

    // protocol engine and result register
    yfr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .interval_written (interval_written),
        .q_not_empty      (q_not_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .busy             (back_busy),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_item         (out_item)
    );

endmodule

>>> design/yfr_front.sv
`timescale 1ns / 1ps
// ============================================================================
// yfr_front: input acceptance and classification
// Decode the command and flag the framing bytes before queueing the item.
// ============================================================================
module yfr_front
    import yfr_pkg::*;
(
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    input  logic      q_full,
    input  logic      back_busy,
    output logic      q_push,
    output cls_item_t q_item
);

    assign in_ready = !q_full && !back_busy;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        case (in_item.cmd)
            CmdByte:  q_item.kind = K_BYTE;
            CmdTick:  q_item.kind = K_TICK;
            CmdStart: q_item.kind = K_START;
            default:  q_item.kind = K_NOP;
        endcase
        q_item.data     = in_item.rx_byte;
        q_item.is_soh   = (in_item.rx_byte == ByteSoh);
        q_item.is_stx   = (in_item.rx_byte == ByteStx);
        q_item.is_eot   = (in_item.rx_byte == ByteEot);
        q_item.is_nul   = (in_item.rx_byte == 8'h00);
        q_item.is_space = (in_item.rx_byte == ByteSpace);
    end

endmodule

>>> design/yfr_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// yfr_queue: short item queue between front and back
// Two-entry register queue; push and pop may happen in the same cycle.
// ============================================================================
module yfr_queue
    import yfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cls_item_t push_item,
    input  logic      pop,
    output logic      not_empty,
    output logic      full,
    output cls_item_t head
);

    cls_item_t  mem_reg [QueueDepth];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'(QueueDepth));
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> design/yfr_back.sv
`timescale 1ns / 1ps
// ============================================================================
// yfr_back: protocol engine and result register
// Run YMODEM receive state at one item per cycle unless stalled; hold result.
// ============================================================================
module yfr_back
    import yfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      interval_written,
    input  logic      q_not_empty,
    input  cls_item_t q_head,
    output logic      q_pop,
    output logic      busy,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    phase_t      phase_reg, phase_next;
    logic [10:0] count_reg, count_next;
    logic        long_reg, long_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [7:0]  expect_reg, expect_next;
    logic [31:0] remain_reg, remain_next;
    logic [7:0]  tick_reg, tick_next;
    logic [7:0]  nakrem_reg, nakrem_next;
    logic [1:0]  spp_reg, spp_next;
    logic [31:0] acc_reg, acc_next;
    logic        name_reg, name_next;
    logic        infile_reg, infile_next;

    // tick remainder recompute after an interval change (restoring division)
    logic        div_busy_reg, div_busy_next;
    logic [2:0]  div_step_reg, div_step_next;
    logic [7:0]  div_r_reg, div_r_next;
    logic [8:0]  div_shift;
    logic [8:0]  div_sub;

    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;

    logic [10:0] blk_len;
    logic [7:0]  tick_inc;
    logic [7:0]  rem_inc;
    logic [9:0]  pidx;
    logic [15:0] rcrc_full;
    logic [31:0] keep;
    logic [31:0] acc_mul;

    assign busy      = div_busy_reg;
    assign q_pop     = q_not_empty && !div_busy_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign div_shift = {div_r_reg, tick_reg[div_step_reg]};
    assign div_sub   = div_shift - {1'b0, cfg.nak_interval};

    always_comb
    begin
        div_busy_next = div_busy_reg;
        div_step_next = div_step_reg;
        div_r_next    = div_r_reg;
        if (interval_written)
        begin
            div_busy_next = 1'b1;
            div_step_next = 3'd7;
            div_r_next    = 8'd0;
        end
        else if (div_busy_reg)
        begin
            div_r_next    = (div_shift >= {1'b0, cfg.nak_interval}) ? div_sub[7:0]
                                                                     : div_shift[7:0];
            div_step_next = div_step_reg - 3'd1;
            if (div_step_reg == 3'd0)
                div_busy_next = 1'b0;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        long_next   = long_reg;
        hdr_next    = hdr_reg;
        crc_next    = crc_reg;
        rcrc_next   = rcrc_reg;
        expect_next = expect_reg;
        remain_next = remain_reg;
        tick_next   = tick_reg;
        nakrem_next = nakrem_reg;
        spp_next    = spp_reg;
        acc_next    = acc_reg;
        name_next   = name_reg;
        infile_next = infile_reg;
        out_item_next = '0;

        blk_len   = long_reg ? LongLen : ShortLen;
        tick_inc  = tick_reg + 8'd1;
        rem_inc   = (nakrem_reg + 8'd1 == cfg.nak_interval) ? 8'd0 : nakrem_reg + 8'd1;
        pidx      = 10'(count_reg - 11'd3);
        rcrc_full = rcrc_reg | {8'h00, q_head.data};
        keep      = (remain_reg < {21'd0, blk_len}) ? remain_reg : {21'd0, blk_len};
        acc_mul   = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                    + {24'd0, q_head.data} - {24'd0, ByteZero};

        if (div_busy_reg && !div_busy_next)
            nakrem_next = div_r_next;

        if (q_pop)
        begin
            case (q_head.kind)
                K_START:
                begin
                    phase_next  = PH_WAIT;
                    count_next  = 11'd0;
                    expect_next = 8'd0;
                    remain_next = 32'd0;
                    tick_next   = 8'd0;
                    nakrem_next = 8'd0;
                    infile_next = 1'b0;
                    spp_next    = 2'd0;
                    acc_next    = 32'd0;
                    name_next   = 1'b0;
                    out_item_next.response = RespC;
                end
                K_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        tick_next   = tick_inc;
                        nakrem_next = rem_inc;
                        if (tick_inc >= cfg.timeout)
                        begin
                            out_item_next.response       = RespCan;
                            out_item_next.session_status = StatTimeout;
                            phase_next = PH_IDLE;
                            count_next = 11'd0;
                        end
                        else if ((phase_reg == PH_WAIT || phase_reg == PH_BLOCK)
                                 && cfg.nak_interval != 8'd0 && rem_inc == 8'd0)
                        begin
                            out_item_next.response = RespNak;
                            phase_next = PH_WAIT;
                            count_next = 11'd0;
                        end
                    end
                end
                K_BYTE:
                begin
                    case (phase_reg)
                        PH_WAIT:
                        begin
                            if (q_head.is_soh || (q_head.is_stx && cfg.long_blocks))
                            begin
                                long_next  = q_head.is_stx;
                                count_next = 11'd1;
                                hdr_next   = 8'd0;
                                crc_next   = 16'd0;
                                rcrc_next  = 16'd0;
                                spp_next   = 2'd0;
                                acc_next   = 32'd0;
                                name_next  = 1'b0;
                                phase_next = PH_BLOCK;
                            end
                            else
                            begin
                                out_item_next.response = RespNak;
                                if (q_head.is_eot)
                                    phase_next = PH_EOT;
                            end
                        end
                        PH_EOT:
                        begin
                            if (q_head.is_eot)
                            begin
                                out_item_next.close_file = 1'b1;
                                out_item_next.response   = RespC;
                                infile_next = 1'b0;
                                expect_next = 8'd0;
                                remain_next = 32'd0;
                                phase_next  = PH_WAIT;
                            end
                        end
                        PH_BLOCK:
                        begin
                            count_next = count_reg + 11'd1;
                            if (count_reg == 11'd1)
                                hdr_next = q_head.data;
                            else if (count_reg >= 11'd3 && count_reg < blk_len + 11'd3)
                            begin
                                out_item_next.payload_valid = 1'b1;
                                out_item_next.payload_byte  = q_head.data;
                                out_item_next.payload_index = pidx;
                                crc_next = crc_add(crc_reg, q_head.data);
                                if (pidx == 10'd0 && !q_head.is_nul)
                                    name_next = 1'b1;
                                if (spp_reg == 2'd0)
                                begin
                                    if (q_head.is_nul)
                                        spp_next = 2'd1;
                                end
                                else if (spp_reg == 2'd1)
                                begin
                                    if (q_head.is_nul || q_head.is_space)
                                        spp_next = 2'd2;
                                    else
                                        acc_next = acc_mul;
                                end
                            end
                            else if (count_reg == blk_len + 11'd3)
                                rcrc_next = {q_head.data, 8'h00};
                            else if (count_reg >= blk_len + 11'd4)
                            begin
                                rcrc_next  = rcrc_full;
                                phase_next = PH_WAIT;
                                count_next = 11'd0;
                                if (hdr_reg != expect_reg || crc_reg != rcrc_full)
                                    out_item_next.response = RespNak;
                                else if (!infile_reg && !name_reg)
                                begin
                                    out_item_next.response       = RespCan;
                                    out_item_next.session_status = StatDone;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    if (!infile_reg)
                                    begin
                                        out_item_next.open_file = 1'b1;
                                        out_item_next.file_size = acc_reg;
                                        remain_next = acc_reg;
                                        infile_next = 1'b1;
                                    end
                                    else
                                    begin
                                        out_item_next.commit_length = keep[10:0];
                                        remain_next = remain_reg - keep;
                                    end
                                    expect_next = expect_reg + 8'd1;
                                    tick_next   = 8'd0;
                                    nakrem_next = 8'd0;
                                    out_item_next.response = RespAck;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        out_valid_next = q_pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= 11'd0;
            long_reg      <= 1'b0;
            hdr_reg       <= 8'd0;
            crc_reg       <= 16'd0;
            rcrc_reg      <= 16'd0;
            expect_reg    <= 8'd0;
            remain_reg    <= 32'd0;
            tick_reg      <= 8'd0;
            nakrem_reg    <= 8'd0;
            spp_reg       <= 2'd0;
            acc_reg       <= 32'd0;
            name_reg      <= 1'b0;
            infile_reg    <= 1'b0;
            div_busy_reg  <= 1'b0;
            div_step_reg  <= 3'd0;
            div_r_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            long_reg      <= long_next;
            hdr_reg       <= hdr_next;
            crc_reg       <= crc_next;
            rcrc_reg      <= rcrc_next;
            expect_reg    <= expect_next;
            remain_reg    <= remain_next;
            tick_reg      <= tick_next;
            nakrem_reg    <= nakrem_next;
            spp_reg       <= spp_next;
            acc_reg       <= acc_next;
            name_reg      <= name_next;
            infile_reg    <= infile_next;
            div_busy_reg  <= div_busy_next;
            div_step_reg  <= div_step_next;
            div_r_reg     <= div_r_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_item_reg <= out_item_next;
    end

    a_pop_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg)
        else $error("popped item did not reach the result register");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> !q_pop)
        else $error("item popped during remainder recompute");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_item_reg))
        else $error("result changed while stalled");

    a_status_can: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.session_status != StatRun)
            |-> out_item_reg.response == RespCan)
        else $error("session end without CAN");

endmodule
